### sv/mspm_pkg.sv
`default_nettype none

package mspm_pkg;

    // Default sizing of the dictionary
    localparam int MAX_NODES_DEF = 1024;
    localparam int ALPHABET_DEF  = 26;

    // Fixed field widths
    localparam int OP_W        = 2;
    localparam int SYM_W       = 5;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Input item operations
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SCAN   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Result item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_MATCH  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_CLR_START,
        CMD_CLR_STEP,
        CMD_CLR_DONE,
        CMD_CLR_EMIT,
        CMD_INS_RD,
        CMD_INS_UPD,
        CMD_RB_INIT,
        CMD_RB_Q,
        CMD_RB_U,
        CMD_RB_L,
        CMD_RB_C1,
        CMD_RB_C2,
        CMD_RB_C3,
        CMD_RB_DONE,
        CMD_SC_RD,
        CMD_SC_NODE,
        CMD_SC_E,
        CMD_SC_STEP,
        CMD_SC_LOAD,
        CMD_SC_FIN
    } t_dp_cmd;

    // Datapath status back to the controller
    typedef struct packed {
        logic tables_valid;
        logic child_none;
        logic last_c;
        logic q_empty;
        logic e_stop;
        logic clr_last;
        logic out_busy;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/multi_pattern_string_matcher_unit.sv
// Insert item: read the child table, then update it. Scan item: goto read, node read,
// exit load, then one exit-chain step per dictionary word found at that position; the
// first scan after the dictionary changes first rebuilds the links, node by node and
// letter by letter (one memory port each). Clear item: one child-table entry per cycle.
// Reset (synchronous, active low) runs the same clearing pass; no input item is
// taken until it ends.
`default_nettype none

module multi_pattern_string_matcher_unit #(
    parameter int MAX_NODES = mspm_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = mspm_pkg::ALPHABET_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [mspm_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // [4:0] symbol, rest zero
    input  wire [mspm_pkg::OP_W-1:0]         i_s_tuser,  // [1:0] op
    input  wire                              i_s_tlast,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [mspm_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // [31:0] match_count, [32] trie_full
    output logic [mspm_pkg::KIND_W-1:0]      o_m_tuser   // [1:0] kind
);
    import mspm_pkg::*;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [COUNT_W-1:0] out_count;
    logic               out_full;

    mspm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    mspm_dp #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sym       (i_s_tdata[SYM_W-1:0]),
        .i_last      (i_s_tlast),
        .i_out_ready (i_m_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_tvalid),
        .o_out_kind  (o_m_tuser),
        .o_out_count (out_count),
        .o_out_full  (out_full)
    );

    assign o_m_tdata = {(OUT_TDATA_W - COUNT_W - 1)'(0), out_full, out_count};

`ifndef SYNTHESIS
    // Work commands only run while the input side is closed
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd != CMD_NOP && cmd != CMD_LATCH) |-> !o_s_tready)
        else $error("datapath command while input open");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.out_busy && stat.last) |-> (cmd != CMD_INS_UPD && cmd != CMD_SC_FIN))
        else $error("result overwritten");

    // A clear result never reports a full trie
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_CLEAR) |-> !o_m_tdata[COUNT_W])
        else $error("clear result with trie_full set");
`endif

endmodule

`default_nettype wire

### sv/mspm_dp.sv
`default_nettype none

module mspm_dp #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mspm_pkg::t_dp_cmd            i_cmd,
    input  wire [mspm_pkg::SYM_W-1:0]    i_sym,
    input  wire                          i_last,
    input  wire                          i_out_ready,
    output mspm_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic [mspm_pkg::KIND_W-1:0]  o_out_kind,
    output logic [mspm_pkg::COUNT_W-1:0] o_out_count,
    output logic                         o_out_full
);
    import mspm_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int QW    = NW + 1;
    localparam int DEPTH = MAX_NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(ALPHABET);

    // Memories: trie children carry a none marker in the top bit
    logic [NW:0]   m_child [DEPTH];
    logic [NW-1:0] m_goto  [DEPTH];
    logic [NW-1:0] m_sfx   [MAX_NODES];
    logic [NW-1:0] m_exit  [MAX_NODES];
    logic          m_wend  [MAX_NODES];
    logic [NW-1:0] m_queue [MAX_NODES];

    logic [NW:0]   r_child_rd;
    logic [NW-1:0] r_goto_rd, r_sfx_rd, r_exit_rd, r_queue_rd;
    logic          r_wend_rd;

    logic          child_we, child_re, goto_we, goto_re;
    logic [AW-1:0] child_wa, child_ra, goto_wa, goto_ra;
    logic [NW:0]   child_wd;
    logic [NW-1:0] goto_wd;
    logic          sfx_we, sfx_re, exit_we, exit_re, wend_we, wend_re, queue_we, queue_re;
    logic [NW-1:0] sfx_wa, sfx_ra, sfx_wd, exit_wa, exit_ra, exit_wd;
    logic [NW-1:0] wend_wa, wend_ra, queue_wa, queue_ra, queue_wd;
    logic          wend_wd;

    // Registers
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_addr, n_addr;
    logic [NW-1:0]      r_cur, n_cur;
    logic [NW-1:0]      r_scan, n_scan;
    logic [NW-1:0]      r_ncnt, n_ncnt;
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_ovf, n_ovf;
    logic               r_broken, n_broken;
    logic               r_valid, n_valid;
    logic [QW-1:0]      r_head, n_head, r_tail, n_tail;
    logic [NW-1:0]      r_u, n_u, r_v, n_v, r_via, n_via, r_e, n_e;
    logic [AW-1:0]      r_ubase, n_ubase, r_lbase, n_lbase;
    logic [CW-1:0]      r_c, n_c;
    logic               r_o_valid, n_o_valid;
    logic [KIND_W-1:0]  r_o_kind, n_o_kind;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic               r_o_full, n_o_full;

    // Helpers
    logic          sym_ok, ins_go, ins_broken, ins_ovf;
    logic [NW-1:0] ins_cur, ins_ncnt, via, snode;

    assign sym_ok = (9'(r_sym) < 9'(ALPHABET));
    assign ins_go = !r_broken && sym_ok;
    assign via    = (r_u == '0) ? '0 : r_goto_rd;
    assign snode  = (sym_ok && (QW'(r_goto_rd) < QW'(MAX_NODES))) ? r_goto_rd : '0;

    // Insert step: follow or create the child, or flag overflow when the trie is full
    always_comb begin
        ins_cur    = r_cur;
        ins_broken = r_broken;
        ins_ovf    = r_ovf;
        ins_ncnt   = r_ncnt;
        if (ins_go) begin
            if (r_child_rd[NW]) begin
                if (QW'(r_ncnt) + QW'(1) < QW'(MAX_NODES)) begin
                    ins_ncnt = r_ncnt + NW'(1);
                    ins_cur  = ins_ncnt;
                end else begin
                    ins_ovf    = 1'b1;
                    ins_broken = 1'b1;
                end
            end else begin
                ins_cur = r_child_rd[NW-1:0];
            end
        end
    end

    // Command decode
    always_comb begin
        n_sym = r_sym;   n_last = r_last;   n_clr = r_clr;     n_addr = r_addr;
        n_cur = r_cur;   n_scan = r_scan;   n_ncnt = r_ncnt;   n_total = r_total;
        n_ovf = r_ovf;   n_broken = r_broken; n_valid = r_valid;
        n_head = r_head; n_tail = r_tail;   n_u = r_u;  n_v = r_v;  n_via = r_via;
        n_e = r_e;       n_ubase = r_ubase; n_lbase = r_lbase; n_c = r_c;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_kind = r_o_kind; n_o_count = r_o_count; n_o_full = r_o_full;
        child_we = 1'b0; child_wa = '0; child_wd = '0; child_re = 1'b0; child_ra = '0;
        goto_we = 1'b0;  goto_wa = '0;  goto_wd = '0;  goto_re = 1'b0;  goto_ra = '0;
        sfx_we = 1'b0;   sfx_wa = '0;   sfx_wd = '0;   sfx_re = 1'b0;   sfx_ra = '0;
        exit_we = 1'b0;  exit_wa = '0;  exit_wd = '0;  exit_re = 1'b0;  exit_ra = '0;
        wend_we = 1'b0;  wend_wa = '0;  wend_wd = 1'b0; wend_re = 1'b0; wend_ra = '0;
        queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_re = 1'b0; queue_ra = '0;
        case (i_cmd)
            CMD_LATCH: begin
                n_sym  = i_sym;
                n_last = i_last;
            end
            CMD_CLR_START: begin
                n_clr = '0;  n_cur = '0;  n_scan = '0;  n_total = '0;  n_ncnt = '0;
                n_ovf = 1'b0; n_broken = 1'b0; n_valid = 1'b0;
            end
            CMD_CLR_STEP: begin
                child_we = 1'b1;
                child_wa = r_clr;
                child_wd = '1;
                if (r_clr < AW'(MAX_NODES)) begin
                    wend_we = 1'b1;
                    wend_wa = r_clr[NW-1:0];
                end
                n_clr = r_clr + AW'(1);
            end
            CMD_CLR_EMIT: begin
                n_o_valid = 1'b1;
                n_o_kind  = KIND_CLEAR;
                n_o_count = '0;
                n_o_full  = 1'b0;
            end
            CMD_INS_RD: begin
                n_addr   = AW'(r_cur) * AW'(ALPHABET) + AW'(r_sym);
                child_re = ins_go;
                child_ra = n_addr;
            end
            CMD_INS_UPD: begin
                n_ovf    = ins_ovf;
                n_ncnt   = ins_ncnt;
                n_cur    = ins_cur;
                n_broken = ins_broken;
                if (ins_go && r_child_rd[NW] && !ins_broken) begin
                    child_we = 1'b1;
                    child_wa = r_addr;
                    child_wd = {1'b0, ins_ncnt};
                    n_valid  = 1'b0;
                end
                if (r_last) begin
                    if (!ins_broken) begin
                        wend_we = 1'b1;
                        wend_wa = ins_cur;
                        wend_wd = 1'b1;
                        n_valid = 1'b0;
                    end
                    n_cur     = '0;
                    n_broken  = 1'b0;
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_INSERT;
                    n_o_count = '0;
                    n_o_full  = ins_ovf;
                end
            end
            CMD_RB_INIT: begin
                sfx_we   = 1'b1;
                exit_we  = 1'b1;
                queue_we = 1'b1;
                n_head   = '0;
                n_tail   = QW'(1);
            end
            CMD_RB_Q: begin
                queue_re = 1'b1;
                queue_ra = r_head[NW-1:0];
                n_head   = r_head + QW'(1);
            end
            CMD_RB_U: begin
                n_u     = r_queue_rd;
                sfx_re  = 1'b1;
                sfx_ra  = r_queue_rd;
                n_ubase = AW'(r_queue_rd) * AW'(ALPHABET);
            end
            CMD_RB_L: begin
                n_lbase = AW'(r_sfx_rd) * AW'(ALPHABET);
                n_c     = '0;
            end
            CMD_RB_C1: begin
                child_re = 1'b1;
                child_ra = r_ubase + AW'(r_c);
                goto_re  = 1'b1;
                goto_ra  = r_lbase + AW'(r_c);
            end
            CMD_RB_C2: begin
                n_v   = r_child_rd[NW-1:0];
                n_via = via;
                if (r_child_rd[NW]) begin
                    goto_we = 1'b1;
                    goto_wa = r_ubase + AW'(r_c);
                    goto_wd = via;
                    n_c     = r_c + CW'(1);
                end else begin
                    wend_re = 1'b1;
                    wend_ra = via;
                    exit_re = 1'b1;
                    exit_ra = via;
                end
            end
            CMD_RB_C3: begin
                sfx_we   = 1'b1;
                sfx_wa   = r_v;
                sfx_wd   = r_via;
                exit_we  = 1'b1;
                exit_wa  = r_v;
                exit_wd  = (r_via == '0 || r_wend_rd) ? r_via : r_exit_rd;
                goto_we  = 1'b1;
                goto_wa  = r_ubase + AW'(r_c);
                goto_wd  = r_v;
                queue_we = 1'b1;
                queue_wa = r_tail[NW-1:0];
                queue_wd = r_v;
                n_tail   = r_tail + QW'(1);
                n_c      = r_c + CW'(1);
            end
            CMD_RB_DONE: begin
                n_valid = 1'b1;
            end
            CMD_SC_RD: begin
                goto_re = sym_ok;
                goto_ra = AW'(r_scan) * AW'(ALPHABET) + AW'(r_sym);
            end
            CMD_SC_NODE: begin
                n_scan  = snode;
                wend_re = 1'b1;
                wend_ra = snode;
                exit_re = 1'b1;
                exit_ra = snode;
            end
            CMD_SC_E: begin
                n_e = !sym_ok ? '0 : (r_wend_rd ? r_scan : r_exit_rd);
            end
            CMD_SC_STEP: begin
                if (r_total != '1) n_total = r_total + COUNT_W'(1);
                exit_re = 1'b1;
                exit_ra = r_e;
            end
            CMD_SC_LOAD: begin
                n_e = r_exit_rd;
            end
            CMD_SC_FIN: begin
                if (r_last) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_MATCH;
                    n_o_count = r_total;
                    n_o_full  = r_ovf;
                    n_scan    = '0;
                    n_total   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (child_we) m_child[child_wa] <= child_wd;
        if (child_re) r_child_rd <= m_child[child_ra];
    end
    always_ff @(posedge i_clk) begin
        if (goto_we) m_goto[goto_wa] <= goto_wd;
        if (goto_re) r_goto_rd <= m_goto[goto_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sfx_we) m_sfx[sfx_wa] <= sfx_wd;
        if (sfx_re) r_sfx_rd <= m_sfx[sfx_ra];
    end
    always_ff @(posedge i_clk) begin
        if (exit_we) m_exit[exit_wa] <= exit_wd;
        if (exit_re) r_exit_rd <= m_exit[exit_ra];
    end
    always_ff @(posedge i_clk) begin
        if (wend_we) m_wend[wend_wa] <= wend_wd;
        if (wend_re) r_wend_rd <= m_wend[wend_ra];
    end
    always_ff @(posedge i_clk) begin
        if (queue_we) m_queue[queue_wa] <= queue_wd;
        if (queue_re) r_queue_rd <= m_queue[queue_ra];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;   r_last <= n_last;   r_clr <= n_clr;   r_addr <= n_addr;
        r_head <= n_head; r_tail <= n_tail;   r_u <= n_u;  r_v <= n_v;  r_via <= n_via;
        r_e <= n_e;       r_ubase <= n_ubase; r_lbase <= n_lbase; r_c <= n_c;
        r_o_kind <= n_o_kind; r_o_count <= n_o_count; r_o_full <= n_o_full;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;  r_scan <= '0;  r_ncnt <= '0;  r_total <= '0;
            r_ovf <= 1'b0; r_broken <= 1'b0; r_valid <= 1'b0; r_o_valid <= 1'b0;
        end else begin
            r_cur <= n_cur;  r_scan <= n_scan;  r_ncnt <= n_ncnt;  r_total <= n_total;
            r_ovf <= n_ovf;  r_broken <= n_broken; r_valid <= n_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Status
    assign o_stat.tables_valid = r_valid;
    assign o_stat.child_none   = r_child_rd[NW];
    assign o_stat.last_c       = (r_c == CW'(ALPHABET - 1));
    assign o_stat.q_empty      = (r_head == r_tail);
    assign o_stat.e_stop       = (r_e == '0) || (QW'(r_e) >= QW'(MAX_NODES));
    assign o_stat.clr_last     = (r_clr == AW'(DEPTH - 1));
    assign o_stat.out_busy     = r_o_valid && !i_out_ready;
    assign o_stat.last         = r_last;

    assign o_out_valid = r_o_valid;
    assign o_out_kind  = r_o_kind;
    assign o_out_count = r_o_count;
    assign o_out_full  = r_o_full;

endmodule

`default_nettype wire

### sv/mspm_ctrl.sv
`default_nettype none

module mspm_ctrl (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire [mspm_pkg::OP_W-1:0]   i_op,
    input  mspm_pkg::t_dp_stat         i_stat,
    output logic                       o_ready,
    output mspm_pkg::t_dp_cmd          o_cmd
);
    import mspm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR_INIT, S_CLR, S_CLR_DONE, S_IDLE,
        S_INS_RD, S_INS_UPD,
        S_RB_INIT, S_RB_Q, S_RB_U, S_RB_L, S_RB_C1, S_RB_C2, S_RB_C3, S_RB_NEXT,
        S_SC_RD, S_SC_NODE, S_SC_E, S_SC_CHK, S_SC_LOAD, S_SC_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_emit, n_emit;

    // Next state and command
    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        o_cmd   = CMD_NOP;
        case (r_state)
            S_CLR_INIT: begin
                o_cmd   = CMD_CLR_START;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd = CMD_CLR_STEP;
                if (i_stat.clr_last) n_state = S_CLR_DONE;
            end
            S_CLR_DONE: begin
                if (!(r_emit && i_stat.out_busy)) begin
                    o_cmd   = r_emit ? CMD_CLR_EMIT : CMD_CLR_DONE;
                    n_emit  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd = CMD_LATCH;
                    case (t_op'(i_op))
                        OP_INSERT: n_state = S_INS_RD;
                        OP_SCAN:   n_state = i_stat.tables_valid ? S_SC_RD : S_RB_INIT;
                        OP_CLEAR: begin
                            n_emit  = 1'b1;
                            n_state = S_CLR_INIT;
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                o_cmd   = CMD_INS_RD;
                n_state = S_INS_UPD;
            end
            S_INS_UPD: begin
                if (!(i_stat.last && i_stat.out_busy)) begin
                    o_cmd   = CMD_INS_UPD;
                    n_state = S_IDLE;
                end
            end
            S_RB_INIT: begin
                o_cmd   = CMD_RB_INIT;
                n_state = S_RB_Q;
            end
            S_RB_Q: begin
                o_cmd   = CMD_RB_Q;
                n_state = S_RB_U;
            end
            S_RB_U: begin
                o_cmd   = CMD_RB_U;
                n_state = S_RB_L;
            end
            S_RB_L: begin
                o_cmd   = CMD_RB_L;
                n_state = S_RB_C1;
            end
            S_RB_C1: begin
                o_cmd   = CMD_RB_C1;
                n_state = S_RB_C2;
            end
            S_RB_C2: begin
                o_cmd = CMD_RB_C2;
                if (!i_stat.child_none) n_state = S_RB_C3;
                else if (i_stat.last_c) n_state = S_RB_NEXT;
                else n_state = S_RB_C1;
            end
            S_RB_C3: begin
                o_cmd   = CMD_RB_C3;
                n_state = i_stat.last_c ? S_RB_NEXT : S_RB_C1;
            end
            S_RB_NEXT: begin
                if (i_stat.q_empty) begin
                    o_cmd   = CMD_RB_DONE;
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_RB_Q;
                end
            end
            S_SC_RD: begin
                o_cmd   = CMD_SC_RD;
                n_state = S_SC_NODE;
            end
            S_SC_NODE: begin
                o_cmd   = CMD_SC_NODE;
                n_state = S_SC_E;
            end
            S_SC_E: begin
                o_cmd   = CMD_SC_E;
                n_state = S_SC_CHK;
            end
            // one exit-chain hop per match
            S_SC_CHK: begin
                if (i_stat.e_stop) begin
                    n_state = S_SC_FIN;
                end else begin
                    o_cmd   = CMD_SC_STEP;
                    n_state = S_SC_LOAD;
                end
            end
            S_SC_LOAD: begin
                o_cmd   = CMD_SC_LOAD;
                n_state = S_SC_CHK;
            end
            S_SC_FIN: begin
                if (!(i_stat.last && i_stat.out_busy)) begin
                    o_cmd   = CMD_SC_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire
